// ----- rtl/core/sha256_pkg.sv -----
package sha256_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  localparam logic [7:0] PadByte = 8'h80;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       absorb;     // shift one byte into the block
    logic [7:0] byte_val;   // byte to absorb
    logic       start;      // load working vars, start 64 rounds
    logic       round;      // do one round
    logic       finalise;   // add working vars into hash
    logic       reinit;     // back to initial hash, clear count
    logic       len_latch;  // capture bit length for padding
  } dp_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic [5:0]  pos;       // byte_count mod 64
    logic [63:0] bit_len;   // latched bit length
  } dp_sts_t;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428A2F98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hB5C0FBCF;
      6'd3: k = 32'hE9B5DBA5; 6'd4: k = 32'h3956C25B; 6'd5: k = 32'h59F111F1;
      6'd6: k = 32'h923F82A4; 6'd7: k = 32'hAB1C5ED5; 6'd8: k = 32'hD807AA98;
      6'd9: k = 32'h12835B01; 6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE; 6'd14: k = 32'h9BDC06A7;
      6'd15: k = 32'hC19BF174; 6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC; 6'd20: k = 32'h2DE92C6F;
      6'd21: k = 32'h4A7484AA; 6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D; 6'd26: k = 32'hB00327C8;
      6'd27: k = 32'hBF597FC7; 6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27B70A85;
      6'd33: k = 32'h2E1B2138; 6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB; 6'd38: k = 32'h81C2C92E;
      6'd39: k = 32'h92722C85; 6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3; 6'd44: k = 32'hD192E819;
      6'd45: k = 32'hD6990624; 6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08; 6'd50: k = 32'h2748774C;
      6'd51: k = 32'h34B0BCB5; 6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3; 6'd56: k = 32'h748F82EE;
      6'd57: k = 32'h78A5636F; 6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB; 6'd62: k = 32'hBEF9A3F7;
      default: k = 32'hC67178F2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6A09E667; 3'd1: h = 32'hBB67AE85;
      3'd2: h = 32'h3C6EF372; 3'd3: h = 32'hA54FF53A;
      3'd4: h = 32'h510E527F; 3'd5: h = 32'h9B05688C;
      3'd6: h = 32'h1F83D9AB;
      default: h = 32'h5BE0CD19;
    endcase
    return h;
  endfunction

endpackage

// ----- rtl/core/sha256_dp.sv -----
module sha256_dp import sha256_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output word_t   hash_o [8]
);

  word_t       h_q [8];
  word_t       v_q [8];
  word_t       w_q [16];   // message schedule window, w_q[0] is w[t]
  word_t       part_q;
  logic [63:0] cnt_q;
  logic [63:0] len_q;
  logic [5:0]  t_q;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  word_t s0, s1, w_new, t1, t2, e, a, ch, maj, sig0, sig1;
  word_t pw_d;

  always_comb begin
    s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = s1 + w_q[9] + s0 + w_q[0];
    e     = v_q[4];
    a     = v_q[0];
    sig1  = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    ch    = (e & v_q[5]) ^ (~e & v_q[6]);
    t1    = v_q[7] + sig1 + ch + round_k(t_q) + w_q[0];
    sig0  = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    maj   = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2    = sig0 + maj;
    pw_d  = {part_q[23:0], cmd_i.byte_val};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
      part_q <= '0;
      cnt_q  <= '0;
      len_q  <= '0;
      t_q    <= '0;
    end else begin
      if (cmd_i.len_latch) len_q <= {cnt_q[60:0], 3'b000};
      if (cmd_i.absorb) begin
        cnt_q <= cnt_q + 64'd1;
        if (cnt_q[1:0] == 2'b11) part_q <= '0;
        else                     part_q <= pw_d;
      end
      if (cmd_i.start) t_q <= '0;
      else if (cmd_i.round) t_q <= t_q + 6'd1;
      if (cmd_i.finalise) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.reinit) begin
        for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
        part_q <= '0;
        cnt_q  <= '0;
      end
    end
  end

  // Block and working registers: payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb && cnt_q[1:0] == 2'b11) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= pw_d;
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
    if (cmd_i.start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign sts_o.pos     = cnt_q[5:0];
  assign sts_o.bit_len = len_q;
  assign hash_o        = h_q;

endmodule

// ----- rtl/core/sha256_ctrl.sv -----
module sha256_ctrl import sha256_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       in_mode_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [2:0] out_idx_o,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRound = 3'd1;
  localparam logic [2:0] StFin   = 3'd2;
  localparam logic [2:0] StPad   = 3'd3;
  localparam logic [2:0] StLen   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0] st_q, st_d;
  logic       fin_q, fin_d;     // compression belongs to padding
  logic       len_done_q, len_done_d;  // length bytes are in the block
  logic [2:0] k_q, k_d;         // length byte / output word index
  logic [5:0] r_q, r_d;
  logic       pad_first_q, pad_first_d;

  always_comb begin
    st_d        = st_q;
    fin_d       = fin_q;
    len_done_d  = len_done_q;
    k_d         = k_q;
    r_d         = r_q;
    pad_first_d = pad_first_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (st_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!in_mode_i) begin
            cmd_o.absorb   = 1'b1;
            cmd_o.byte_val = in_byte_i;
            if (sts_i.pos == 6'd63) begin
              st_d = StRound; fin_d = 1'b0;
            end
          end else begin
            cmd_o.len_latch = 1'b1;
            st_d = StPad; pad_first_d = 1'b1;
          end
        end
      end
      StPad: begin
        if (sts_i.pos == 6'd56 && !pad_first_q) begin
          st_d = StLen; k_d = '0;
        end else begin
          cmd_o.absorb   = 1'b1;
          cmd_o.byte_val = pad_first_q ? PadByte : 8'h00;
          pad_first_d    = 1'b0;
          if (sts_i.pos == 6'd63) begin
            st_d = StRound; fin_d = 1'b1;
          end
        end
      end
      StLen: begin
        cmd_o.absorb   = 1'b1;
        cmd_o.byte_val = sts_i.bit_len[8*(7-k_q) +: 8];
        k_d = k_q + 3'd1;
        if (k_q == 3'd7) begin
          st_d = StRound; fin_d = 1'b1; len_done_d = 1'b1;
        end
      end
      StRound: begin
        // first cycle issues start; rounds counted by r_q
        if (r_q == 6'd0 && !pad_first_q) begin
          cmd_o.start = 1'b1;
          pad_first_d = 1'b1;
        end else begin
          cmd_o.round = 1'b1;
          r_d = r_q + 6'd1;
          if (r_q == 6'd63) begin
            st_d = StFin; pad_first_d = 1'b0;
          end
        end
      end
      StFin: begin
        cmd_o.finalise = 1'b1;
        if (fin_q) begin
          st_d = len_done_q ? StOut : StPad;
          k_d = '0;
          len_done_d = 1'b0;
        end else begin
          st_d = StIdle;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          k_d = k_q + 3'd1;
          if (k_q == 3'd7) begin
            cmd_o.reinit = 1'b1;
            st_d = StIdle;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; fin_q <= 1'b0; k_q <= '0; r_q <= '0; pad_first_q <= 1'b0;
      len_done_q <= 1'b0;
    end else begin
      st_q <= st_d; fin_q <= fin_d; k_q <= k_d; r_q <= r_d; pad_first_q <= pad_first_d;
      len_done_q <= len_done_d;
    end
  end

  assign out_idx_o = k_q;

  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> st_q == StOut) else $error("output outside digest phase");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd_o.round && !out_valid_o) else $error("accept while busy");
  a_rounds_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRound && r_q == 6'd63 && cmd_o.round) |=> st_q == StFin)
    else $error("round count overrun");

endmodule

// ----- rtl/core/sha256_byte_stream_hasher_unit.sv -----
// Channel | dir | tdata                        | tuser/tlast
// s_axis  | in  | [7:0] data_byte              | tuser = mode
// m_axis  | out | [31:0] digest_word,[34:32] idx | tlast = last_word
//
// A data beat is taken while idle; the 64th byte of a block adds compression
// (load plus 64 rounds) and then a fold into the hash.
// A finish beat runs padding one byte per cycle, one or two compressions,
// then eight digest beats, each held until m_axis_tready.
// rst_ni is asynchronous, active low, and restores the initial hash.
// s_axis_tready is low throughout compression, padding and digest output.
module sha256_byte_stream_hasher_unit import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast    // last_word
);

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  word_t      hash [8];
  logic [2:0] idx;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .in_mode_i  (s_axis_tuser),  .in_byte_i  (s_axis_tdata),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .out_idx_o  (idx), .sts_i(sts), .cmd_o(cmd)
  );

  sha256_dp u_dp (.clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .hash_o(hash));

  assign m_axis_tdata = {5'b0, idx, hash[idx]};
  assign m_axis_tlast = (idx == 3'd7);

endmodule

// ----- verif/tb.sv -----
module tb;
  import sha256_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  localparam logic ModeData   = 1'b0;
  localparam logic ModeFinish = 1'b1;
  localparam int   IdleLimit  = 20000;
  localparam int   HoldCycles = 600;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
  } beat_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  always #6 clk_i = ~clk_i;

  sha256_byte_stream_hasher_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  // Round constants and initial hash, kept locally
  logic [31:0] rk [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
    32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
    32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
    32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
    32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
  logic [31:0] iv [8] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
                          32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

  // Predictor state
  logic [31:0] hh [8];
  logic [31:0] blk [16];
  logic [31:0] pword;
  logic [63:0] nbytes;

  beat_t        pending_beats[$];
  digest_beat_t expected_digest[$];
  int  mismatches = 0;
  bit  calm = 1'b0;       // no idling in the last part
  bit  hold_sink = 1'b0;  // long receiver hold-off request
  int  hold_cnt = 0;      // hold-off cycles spent so far
  int  idle_cycles = 0;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++) w[t] = blk[t];
    for (int t = 16; t < 64; t++)
      w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    for (int i = 0; i < 8; i++) v[i] = hh[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + rk[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hh[i] += v[i];
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    logic [5:0] pos;
    pos = nbytes[5:0];
    pword = {pword[23:0], b};
    if (pos[1:0] == 2'd3) begin
      blk[pos[5:2]] = pword;
      pword = '0;
    end
    if (pos == 6'd63) compress_block();
    nbytes++;
  endfunction

  function automatic void hash_init();
    for (int i = 0; i < 8; i++) hh[i] = iv[i];
    pword = '0;
    nbytes = '0;
  endfunction

  // Accepted beat: update predictor, queue digest words on a finish
  function automatic void predict_hash(beat_t b);
    logic [63:0] bits;
    if (b.mode == ModeData) begin
      absorb_byte(b.data);
      return;
    end
    bits = nbytes << 3;
    absorb_byte(PadByte);
    while (nbytes[5:0] != 6'd56) absorb_byte(8'h00);
    for (int i = 0; i < 8; i++) absorb_byte(bits[56 - 8*i +: 8]);
    for (int i = 0; i < 8; i++)
      expected_digest.push_back('{hh[i], 3'(i), i == 7});
    hash_init();
  endfunction

  // Driver
  int src_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_hash('{s_axis_tuser, s_axis_tdata});
        void'(pending_beats.pop_front());
      end
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!(s_axis_tvalid && !s_axis_tready)) begin
        // next beat: the head of the queue after any pop above
        if (pending_beats.size() > 0 && !calm && $urandom_range(0, 15) == 0) begin
          src_gap <= $urandom_range(1, 16) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= pending_beats[0].mode;
          s_axis_tdata  <= pending_beats[0].data;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver
  int sink_gap = 0;
  always @(posedge clk_i) begin
    digest_beat_t got, exp_b;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast};
        if (expected_digest.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected digest beat %h", got);
        end else begin
          exp_b = expected_digest.pop_front();
          if (got !== exp_b || m_axis_tdata[39:35] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"digest mismatch: exp word %h idx %0d last %b, ",
                        "got word %h idx %0d last %b"},
                       exp_b.word, exp_b.idx, exp_b.last, got.word, got.idx, got.last);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (hold_sink && hold_cnt < HoldCycles) begin
        hold_cnt <= hold_cnt + 1;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        sink_gap <= $urandom_range(1, 16) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_msg(int len, bit rnd);
    for (int i = 0; i < len; i++)
      pending_beats.push_back('{ModeData, rnd ? 8'($urandom) : 8'(i)});
    pending_beats.push_back('{ModeFinish, 8'($urandom)});
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || s_axis_tvalid || expected_digest.size() > 0)
      @(posedge clk_i);
  endtask

  // Watchdog on stalled progress
  initial begin
    wait (rst_ni);
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int len;
    hash_init();
    for (int i = 0; i < 16; i++) blk[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty message, byte extremes, word boundaries
    push_msg(0, 0);
    pending_beats.push_back('{ModeData, 8'h00});
    pending_beats.push_back('{ModeData, 8'hFF});
    pending_beats.push_back('{ModeFinish, 8'hFF});
    push_msg(3, 0);
    push_msg(4, 0);
    push_msg(5, 1);
    drain();

    // Sender pause until idle, then messages across block sizes
    push_msg(55, 1);
    push_msg(56, 1);
    push_msg(64, 1);
    drain();

    // Receiver holds off while the sender keeps offering finishes
    hold_sink = 1'b1;
    for (int i = 0; i < 4; i++) push_msg($urandom_range(0, 6), 1);
    wait (hold_cnt >= HoldCycles);
    hold_sink = 1'b0;
    drain();

    // Random short messages
    for (int n = 0; n < 20; n++) begin
      len = $urandom_range(0, 8);
      push_msg(len, 1);
      if (n == 14) begin
        drain();
        calm = 1'b1;
      end
    end
    drain();
    repeat (300) @(posedge clk_i);

    if (mismatches == 0 && expected_digest.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
